FILE: design/cbs_pkg.sv
// Shared types and constants for the compass bearing pipeline.
`default_nettype none

package cbs_pkg;

    // Legs are normalized so that the larger one lands in [2^40, 2^41).
    localparam int LEG_W        = 41;
    localparam int NORM_STEPS   = 6;
    // CORDIC datapath: x and y stay below 2^43 in magnitude, angles in 2^-24 degree.
    localparam int XY_W         = 46;
    localparam int Z_W          = 32;
    localparam int ACC_FRAC     = 24;
    localparam int CORDIC_STEPS = 28;
    localparam int BEARING_W    = 17;

    localparam int QUARTER_DEG       = 90;
    localparam int HALF_DEG          = 180;
    localparam int THREE_QUARTER_DEG = 270;
    localparam int FULL_DEG          = 360;

    localparam logic [Z_W-1:0] RIGHT_Z = Z_W'(QUARTER_DEG) << ACC_FRAC;

    // Quadrant of the segment, named by the compass sector it covers.
    typedef enum logic [1:0] {
        QUAD_NE = 2'd0,
        QUAD_SE = 2'd1,
        QUAD_SW = 2'd2,
        QUAD_NW = 2'd3
    } cbs_quad_t;

    typedef struct packed {
        cbs_quad_t quad;
        logic      degen;
        logic      opp_zero;
        logic      adj_zero;
    } cbs_meta_t;

    typedef struct packed {
        logic [LEG_W-1:0] opp;
        logic [LEG_W-1:0] adj;
        cbs_meta_t        meta;
    } cbs_leg_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        cbs_meta_t              meta;
    } cbs_rot_t;

endpackage

`default_nettype wire

FILE: design/cbs_prep.sv
// Front end: coordinate differences, quadrant selection and leg magnitudes.
`default_nettype none

module cbs_prep import cbs_pkg::*; #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] start_x,
    input  logic signed [COORD_WIDTH-1:0] start_y,
    input  logic signed [COORD_WIDTH-1:0] end_x,
    input  logic signed [COORD_WIDTH-1:0] end_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output cbs_leg_t                      out_data
);

    localparam int DW = COORD_WIDTH + 1;

    logic                 va_reg;
    logic                 vb_reg;
    logic                 ld_a;
    logic                 ld_b;
    logic signed [DW-1:0] dx_reg;
    logic signed [DW-1:0] dy_reg;
    logic signed [DW-1:0] dx_next;
    logic signed [DW-1:0] dy_next;
    logic [DW-1:0]        dx_neg;
    logic [DW-1:0]        dy_neg;
    logic [LEG_W-1:0]     ax;
    logic [LEG_W-1:0]     ay;
    logic                 xp;
    logic                 yp;
    cbs_leg_t             leg_reg;
    cbs_leg_t             leg_next;

    assign ld_b     = ~vb_reg | out_ready;
    assign ld_a     = ~va_reg | ld_b;
    assign in_ready = ld_a;

    assign dx_next = DW'(end_x) - DW'(start_x);
    assign dy_next = DW'(end_y) - DW'(start_y);

    always_comb begin
        dx_neg = -dx_reg;
        dy_neg = -dy_reg;
        // A difference never reaches -2^COORD_WIDTH, so the magnitude fits COORD_WIDTH bits.
        ax = LEG_W'(dx_reg[DW-1] ? dx_neg[COORD_WIDTH-1:0] : dx_reg[COORD_WIDTH-1:0]);
        ay = LEG_W'(dy_reg[DW-1] ? dy_neg[COORD_WIDTH-1:0] : dy_reg[COORD_WIDTH-1:0]);
        xp = ~dx_reg[DW-1] & (dx_reg != '0);
        yp = ~dy_reg[DW-1] & (dy_reg != '0);

        // In the SE and NW quadrants the roles of the two legs swap.
        if (xp ^ yp) begin
            leg_next.opp = ay;
            leg_next.adj = ax;
        end else begin
            leg_next.opp = ax;
            leg_next.adj = ay;
        end
        leg_next.meta.quad     = cbs_quad_t'({~xp, xp ^ yp});
        leg_next.meta.degen    = (dx_reg == '0) && (dy_reg == '0);
        leg_next.meta.opp_zero = (leg_next.opp == '0);
        leg_next.meta.adj_zero = (leg_next.adj == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (ld_a) begin
                va_reg <= in_valid;
            end
            if (ld_b) begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_a) begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (ld_b) begin
            leg_reg <= leg_next;
        end
    end

    assign out_valid = vb_reg;
    assign out_data  = leg_reg;

endmodule

`default_nettype wire

FILE: design/cbs_norm.sv
// Staged normalizer: shifts both legs left until the larger one reaches 2^40.
`default_nettype none

module cbs_norm import cbs_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  cbs_leg_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output cbs_leg_t out_data
);

    // One power-of-two shift is decided per stage, from the largest down.
    function automatic cbs_leg_t norm_step(input cbs_leg_t a, input int sh);
        cbs_leg_t r;
        r = a;
        if (((a.opp | a.adj) >> (LEG_W - sh)) == '0) begin
            r.opp = a.opp << sh;
            r.adj = a.adj << sh;
        end
        return r;
    endfunction

    logic [NORM_STEPS-1:0] vld_reg;
    logic [NORM_STEPS-1:0] vld_in;
    wire  [NORM_STEPS:0]   ld;
    cbs_leg_t              stg_reg [NORM_STEPS];
    wire cbs_leg_t         stg_in [NORM_STEPS];
    wire cbs_leg_t         stg_next [NORM_STEPS];

    assign ld[NORM_STEPS] = out_ready;

    genvar i;
    generate
        for (i = 0; i < NORM_STEPS; i++) begin : g_stage
            localparam int SH = 1 << (NORM_STEPS - 1 - i);
            assign ld[i] = ~vld_reg[i] | ld[i+1];
            if (i == 0) begin : g_first
                assign stg_in[i] = in_data;
                assign vld_in[i] = in_valid;
            end else begin : g_rest
                assign stg_in[i] = stg_reg[i-1];
                assign vld_in[i] = vld_reg[i-1];
            end
            assign stg_next[i] = norm_step(stg_in[i], SH);
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < NORM_STEPS; k++) begin
                if (ld[k]) begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NORM_STEPS; k++) begin
            if (ld[k]) begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    assign in_ready  = ld[0];
    assign out_valid = vld_reg[NORM_STEPS-1];
    assign out_data  = stg_reg[NORM_STEPS-1];

endmodule

`default_nettype wire

FILE: design/cbs_cordic.sv
// Vectoring CORDIC, one micro-rotation per pipeline stage.
`default_nettype none

module cbs_cordic import cbs_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  cbs_leg_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output cbs_rot_t out_data
);

    // atan(2^-i) in 2^-24 degree.
    localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
        32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
        32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
        32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
        32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
        32'sd917,       32'sd458,       32'sd229,       32'sd115,
        32'sd57,        32'sd29,        32'sd14,        32'sd7
    };

    function automatic cbs_rot_t load_rot(input cbs_leg_t a);
        cbs_rot_t r;
        r.x    = XY_W'(a.adj);
        r.y    = XY_W'(a.opp);
        r.z    = '0;
        r.meta = a.meta;
        return r;
    endfunction

    // Rotate toward the x axis; a y of zero counts as not positive.
    function automatic cbs_rot_t rotate_step(input cbs_rot_t a, input int sh,
                                             input logic signed [Z_W-1:0] ang);
        cbs_rot_t               r;
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        r  = a;
        xs = a.x >>> sh;
        ys = a.y >>> sh;
        if (!a.y[XY_W-1] && (a.y != '0)) begin
            r.x = a.x + ys;
            r.y = a.y - xs;
            r.z = a.z + ang;
        end else begin
            r.x = a.x - ys;
            r.y = a.y + xs;
            r.z = a.z - ang;
        end
        return r;
    endfunction

    logic [CORDIC_STEPS-1:0] vld_reg;
    logic [CORDIC_STEPS-1:0] vld_in;
    wire  [CORDIC_STEPS:0]   ld;
    cbs_rot_t                stg_reg [CORDIC_STEPS];
    wire cbs_rot_t           stg_in [CORDIC_STEPS];
    wire cbs_rot_t           stg_next [CORDIC_STEPS];

    assign ld[CORDIC_STEPS] = out_ready;

    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++) begin : g_stage
            assign ld[i] = ~vld_reg[i] | ld[i+1];
            if (i == 0) begin : g_first
                assign stg_in[i] = load_rot(in_data);
                assign vld_in[i] = in_valid;
            end else begin : g_rest
                assign stg_in[i] = stg_reg[i-1];
                assign vld_in[i] = vld_reg[i-1];
            end
            assign stg_next[i] = rotate_step(stg_in[i], i, ATAN_TAB[i]);
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                if (ld[k]) begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            if (ld[k]) begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    assign in_ready  = ld[0];
    assign out_valid = vld_reg[CORDIC_STEPS-1];
    assign out_data  = stg_reg[CORDIC_STEPS-1];

endmodule

`default_nettype wire

FILE: design/cbs_final.sv
// Back end: clamp and round the angle, add the quadrant base, wrap the circle.
`default_nettype none

module cbs_final import cbs_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cbs_rot_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [BEARING_W-1:0] bearing,
    output logic                 degenerate
);

    localparam int DROP   = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int Q_W    = 7 + ANGLE_FRAC_BITS;
    localparam int FULL_W = 9 + ANGLE_FRAC_BITS;

    localparam logic [Z_W-1:0]    HALF_LSB = Z_W'(1) << (DROP - 1);
    localparam logic [FULL_W-1:0] BASE_SE  = FULL_W'(QUARTER_DEG) << ANGLE_FRAC_BITS;
    localparam logic [FULL_W-1:0] BASE_SW  = FULL_W'(HALF_DEG) << ANGLE_FRAC_BITS;
    localparam logic [FULL_W-1:0] BASE_NW  = FULL_W'(THREE_QUARTER_DEG) << ANGLE_FRAC_BITS;
    localparam logic [FULL_W-1:0] CIRCLE   = FULL_W'(FULL_DEG) << ANGLE_FRAC_BITS;

    logic                 va_reg;
    logic                 vb_reg;
    logic                 ld_a;
    logic                 ld_b;
    logic [Z_W-1:0]       z_clamp;
    logic [Z_W-1:0]       z_round;
    logic [Q_W-1:0]       q_reg;
    logic [Q_W-1:0]       q_next;
    cbs_meta_t            meta_reg;
    logic [FULL_W-1:0]    base;
    logic [FULL_W-1:0]    sum;
    logic [FULL_W-1:0]    wrapped;
    logic [BEARING_W-1:0] bearing_reg;
    logic [BEARING_W-1:0] bearing_next;
    logic                 degen_reg;

    assign ld_b     = ~vb_reg | out_ready;
    assign ld_a     = ~va_reg | ld_b;
    assign in_ready = ld_a;

    // A leg on an axis bypasses the CORDIC result entirely.
    always_comb begin
        if (in_data.meta.opp_zero) begin
            z_clamp = '0;
        end else if (in_data.meta.adj_zero) begin
            z_clamp = RIGHT_Z;
        end else if (in_data.z[Z_W-1]) begin
            z_clamp = '0;
        end else if (Z_W'(in_data.z) > RIGHT_Z) begin
            z_clamp = RIGHT_Z;
        end else begin
            z_clamp = Z_W'(in_data.z);
        end
        z_round = z_clamp + HALF_LSB;
        q_next  = z_round[DROP +: Q_W];
    end

    always_comb begin
        unique case (meta_reg.quad)
            QUAD_NE: base = '0;
            QUAD_SE: base = BASE_SE;
            QUAD_SW: base = BASE_SW;
            QUAD_NW: base = BASE_NW;
            default: base = '0;
        endcase
        sum = base + FULL_W'(q_reg);
        // Straight up, or within half a step of it from the NW side, folds to zero.
        if (sum >= CIRCLE) begin
            wrapped = sum - CIRCLE;
        end else begin
            wrapped = sum;
        end
        if (meta_reg.degen) begin
            bearing_next = '0;
        end else begin
            bearing_next = BEARING_W'(wrapped);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (ld_a) begin
                va_reg <= in_valid;
            end
            if (ld_b) begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_a) begin
            q_reg    <= q_next;
            meta_reg <= in_data.meta;
        end
        if (ld_b) begin
            bearing_reg <= bearing_next;
            degen_reg   <= meta_reg.degen;
        end
    end

    assign out_valid  = vb_reg;
    assign bearing    = bearing_reg;
    assign degenerate = degen_reg;

endmodule

`default_nettype wire

FILE: design/compass_bearing_of_segment.sv
// Top level of the compass bearing pipeline: prep, normalizer, CORDIC and back end.
// An accepted item passes through 2 front-end stages,
// 6 normalizer stages, 28 CORDIC stages (one micro-rotation each) and 2 back-end stages.
// Throughput is one item per cycle while m_ready is high; every stage holds its own valid bit and
// refills as soon as its contents move on, so bubbles close up while the output is stalled.
// Reset (aresetn, synchronous, active low) clears all valid bits; data registers keep whatever.
`default_nettype none

module compass_bearing_of_segment import cbs_pkg::*; #(
    parameter int COORD_WIDTH     = 24,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_start_x,
    input  logic signed [COORD_WIDTH-1:0] s_start_y,
    input  logic signed [COORD_WIDTH-1:0] s_end_x,
    input  logic signed [COORD_WIDTH-1:0] s_end_y,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [BEARING_W-1:0]          m_bearing,
    output logic                          m_degenerate
);

    // Handshakes between the four sections. Each section's ready is a function of
    // its own valid bits and the ready of the section after it.
    logic     prep_valid;
    logic     prep_ready;
    cbs_leg_t prep_data;
    logic     norm_valid;
    logic     norm_ready;
    cbs_leg_t norm_data;
    logic     rot_valid;
    logic     rot_ready;
    cbs_rot_t rot_data;

    // Differences, quadrant and the two leg magnitudes.
    cbs_prep #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .start_x   (s_start_x),
        .start_y   (s_start_y),
        .end_x     (s_end_x),
        .end_y     (s_end_y),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_data  (prep_data)
    );

    // Left-align both legs by a common shift so the CORDIC sees full precision.
    cbs_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (norm_valid),
        .out_ready (norm_ready),
        .out_data  (norm_data)
    );

    // Arctangent of opposite over adjacent leg, accumulated in 2^-24 degree.
    cbs_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (norm_valid),
        .in_ready  (norm_ready),
        .in_data   (norm_data),
        .out_valid (rot_valid),
        .out_ready (rot_ready),
        .out_data  (rot_data)
    );

    // Clamp, round, add the quadrant base and drive the output register.
    cbs_final #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_final (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (rot_valid),
        .in_ready   (rot_ready),
        .in_data    (rot_data),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .bearing    (m_bearing),
        .degenerate (m_degenerate)
    );

endmodule

`default_nettype wire
